// ===== rtl/core/lpat_pkg.sv =====
`default_nettype none
package lpat_pkg;

  // field widths
  localparam int unsigned KEY_W    = 64;
  localparam int unsigned MAC_W    = 48;
  localparam int unsigned TIME_W   = 64;
  localparam int unsigned STATUS_W = 3;
  localparam int unsigned SLOT_W   = 4;
  localparam int unsigned FILL_W   = 5;

  // default table size
  localparam int unsigned DEPTH_DEF = 16;

  typedef logic [STATUS_W-1:0] status_t;

  // result status codes
  localparam status_t STS_REFRESH = 3'd0;
  localparam status_t STS_INSERT  = 3'd1;
  localparam status_t STS_EVICT   = 3'd2;
  localparam status_t STS_HIT     = 3'd3;
  localparam status_t STS_MISS    = 3'd4;

  // operation codes
  typedef enum logic {
    OP_ADD    = 1'b0,
    OP_LOOKUP = 1'b1
  } op_t;

  // sequencer states
  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_DECIDE,
    S_DONE
  } seq_state_t;

  // flags from the shared compare unit
  typedef struct packed {
    logic key_eq;
    logic seen_lt;
  } cmp_res_t;

endpackage
`default_nettype wire

// ===== rtl/core/lpat_store.sv =====
`default_nettype none
module lpat_store #(
  parameter int unsigned TABLE_DEPTH = lpat_pkg::DEPTH_DEF,
  parameter int unsigned IW          = $clog2(TABLE_DEPTH)
) (
  input  wire logic                       clk,
  input  wire logic                       rd_en,
  input  wire logic [IW-1:0]              rd_addr,
  output logic      [lpat_pkg::KEY_W-1:0] rd_key,
  output logic      [lpat_pkg::MAC_W-1:0] rd_mac,
  output logic      [lpat_pkg::TIME_W-1:0] rd_seen,
  input  wire logic                       we_entry,
  input  wire logic                       we_seen,
  input  wire logic [IW-1:0]              wr_addr,
  input  wire logic [lpat_pkg::KEY_W-1:0] wr_key,
  input  wire logic [lpat_pkg::MAC_W-1:0] wr_mac,
  input  wire logic [lpat_pkg::TIME_W-1:0] wr_seen
);
  import lpat_pkg::*;

  logic [KEY_W-1:0]  key_mem  [TABLE_DEPTH];
  logic [MAC_W-1:0]  mac_mem  [TABLE_DEPTH];
  logic [TIME_W-1:0] seen_mem [TABLE_DEPTH];

  // write port: whole entry or stamp only
  always_ff @(posedge clk) begin
    if (we_entry) begin
      key_mem[wr_addr] <= wr_key;
      mac_mem[wr_addr] <= wr_mac;
    end
    if (we_entry || we_seen) begin
      seen_mem[wr_addr] <= wr_seen;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_key  <= key_mem[rd_addr];
      rd_mac  <= mac_mem[rd_addr];
      rd_seen <= seen_mem[rd_addr];
    end
  end

endmodule
`default_nettype wire

// ===== rtl/core/lpat_cmp.sv =====
`default_nettype none
module lpat_cmp (
  input  wire logic [lpat_pkg::KEY_W-1:0]  key_a,
  input  wire logic [lpat_pkg::KEY_W-1:0]  key_b,
  input  wire logic [lpat_pkg::TIME_W-1:0] seen_a,
  input  wire logic [lpat_pkg::TIME_W-1:0] seen_b,
  output lpat_pkg::cmp_res_t               res
);
  import lpat_pkg::*;

  // key match and unsigned stamp order
  always_comb begin
    res.key_eq  = (key_a == key_b);
    res.seen_lt = (seen_a < seen_b);
  end

endmodule
`default_nettype wire

// ===== rtl/core/lru_peer_address_table_core.sv =====
`default_nettype none
// channel | direction | ports
// in      | input     | in_valid, in_ready, in_op, in_peer_key, in_peer_mac, in_now_us
// out     | output    | out_valid, out_ready, out_status, out_slot, out_mac_out, out_fill_count
//
// when no key matches, an item scans every filled entry before the decision; a match ends
// the scan early, and an empty table skips the scan. the scan reads one entry a cycle
// through the single registered read port of the entry memory and compares it in the
// following cycle, then the decide state writes back and the done state hands the beat
// to the output.
// rst_n clears the sequencer, the fill count and the output valid; entries stay unknown.
// in_ready is high only while the sequencer is idle; a beat held by out_ready low
// stalls the next item only once that item's result is ready to leave.
module lru_peer_address_table_core #(
  parameter int unsigned TABLE_DEPTH = lpat_pkg::DEPTH_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          in_valid,
  output logic                               in_ready,
  input  wire logic                          in_op,
  input  wire logic [lpat_pkg::KEY_W-1:0]    in_peer_key,
  input  wire logic [lpat_pkg::MAC_W-1:0]    in_peer_mac,
  input  wire logic [lpat_pkg::TIME_W-1:0]   in_now_us,
  output logic                               out_valid,
  input  wire logic                          out_ready,
  output logic      [lpat_pkg::STATUS_W-1:0] out_status,
  output logic      [lpat_pkg::SLOT_W-1:0]   out_slot,
  output logic      [lpat_pkg::MAC_W-1:0]    out_mac_out,
  output logic      [lpat_pkg::FILL_W-1:0]   out_fill_count
);
  import lpat_pkg::*;

  localparam int unsigned IW = $clog2(TABLE_DEPTH);
  localparam int unsigned CW = $clog2(TABLE_DEPTH + 1);
  localparam logic [CW-1:0] FULL_CNT = CW'(TABLE_DEPTH);

  seq_state_t state_r, state_nxt;

  // captured item
  logic              op_r;
  logic [KEY_W-1:0]  key_r;
  logic [MAC_W-1:0]  mac_r;
  logic [TIME_W-1:0] now_r;

  logic [CW-1:0]     count_r, count_nxt;
  logic [CW-1:0]     issue_cnt_r, issue_cnt_nxt;
  logic              rd_vld_r, rd_vld_nxt;
  logic [IW-1:0]     cmp_idx_r;

  logic              hit_r, hit_nxt;
  logic [IW-1:0]     hit_idx_r;
  logic [MAC_W-1:0]  hit_mac_r;
  logic              best_vld_r, best_vld_nxt;
  logic [IW-1:0]     best_idx_r;
  logic [TIME_W-1:0] best_seen_r;

  status_t           res_status_r;
  logic [IW-1:0]     res_slot_r;
  logic [MAC_W-1:0]  res_mac_r;

  logic              out_valid_r, out_valid_nxt;
  status_t           out_status_r;
  logic [SLOT_W-1:0] out_slot_r;
  logic [MAC_W-1:0]  out_mac_r;
  logic [FILL_W-1:0] out_fill_r;

  // memory and compare unit wiring
  logic [KEY_W-1:0]  rd_key;
  logic [MAC_W-1:0]  rd_mac;
  logic [TIME_W-1:0] rd_seen;
  logic              issue;
  logic              we_entry, we_seen;
  logic [IW-1:0]     wr_addr;
  cmp_res_t          cmp;

  logic              in_fire, out_free;
  logic              match, scan_last, take_old;
  logic [CW-1:0]     cmp_idx_ext;
  logic [CW+FILL_W-1:0] fill_ext;
  logic [IW+SLOT_W-1:0] slot_ext;
  status_t           dec_status;
  logic [IW-1:0]     dec_slot;
  logic [MAC_W-1:0]  dec_mac;

  lpat_store #(
    .TABLE_DEPTH (TABLE_DEPTH),
    .IW          (IW)
  ) u_store (
    .clk      (clk),
    .rd_en    (issue),
    .rd_addr  (issue_cnt_r[IW-1:0]),
    .rd_key   (rd_key),
    .rd_mac   (rd_mac),
    .rd_seen  (rd_seen),
    .we_entry (we_entry),
    .we_seen  (we_seen),
    .wr_addr  (wr_addr),
    .wr_key   (key_r),
    .wr_mac   (mac_r),
    .wr_seen  (now_r)
  );

  lpat_cmp u_cmp (
    .key_a  (rd_key),
    .key_b  (key_r),
    .seen_a (rd_seen),
    .seen_b (best_seen_r),
    .res    (cmp)
  );

  // scan status
  always_comb begin
    cmp_idx_ext = CW'(cmp_idx_r);
    match       = rd_vld_r && cmp.key_eq;
    scan_last   = rd_vld_r && (CW'(cmp_idx_ext + CW'(1)) == count_r);
    take_old    = rd_vld_r && (!best_vld_r || cmp.seen_lt);
    in_fire     = in_valid && in_ready;
    out_free    = !out_valid_r || out_ready;
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          state_nxt = (count_r == '0) ? S_DECIDE : S_SCAN;
        end
      end
      S_SCAN: begin
        if (match || scan_last) begin
          state_nxt = S_DECIDE;
        end
      end
      S_DECIDE: state_nxt = S_DONE;
      S_DONE: begin
        if (out_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // sequencer outputs
  always_comb begin
    in_ready = 1'b0;
    issue    = 1'b0;
    unique case (state_r)
      S_IDLE:   in_ready = 1'b1;
      S_SCAN:   issue    = (issue_cnt_r < count_r) && !match && !scan_last;
      S_DECIDE: ;
      S_DONE:   ;
      default:  ;
    endcase
  end

  // decision on the scanned table
  always_comb begin
    dec_status = STS_MISS;
    dec_slot   = '0;
    dec_mac    = '0;
    we_entry   = 1'b0;
    we_seen    = 1'b0;
    count_nxt  = count_r;
    if (op_r == OP_ADD) begin
      priority if (hit_r) begin
        dec_status = STS_REFRESH;
        dec_slot   = hit_idx_r;
      end else if (count_r != FULL_CNT) begin
        dec_status = STS_INSERT;
        dec_slot   = count_r[IW-1:0];
        count_nxt  = CW'(count_r + CW'(1));
      end else begin
        dec_status = STS_EVICT;
        dec_slot   = best_idx_r;
      end
      we_entry = (state_r == S_DECIDE);
    end else if (hit_r) begin
      dec_status = STS_HIT;
      dec_slot   = hit_idx_r;
      dec_mac    = hit_mac_r;
      we_seen    = (state_r == S_DECIDE);
    end
    if (state_r != S_DECIDE) begin
      count_nxt = count_r;
    end
    wr_addr = dec_slot;
  end

  // scan bookkeeping
  always_comb begin
    issue_cnt_nxt = issue_cnt_r;
    rd_vld_nxt    = issue;
    hit_nxt       = hit_r;
    best_vld_nxt  = best_vld_r;
    if (in_fire) begin
      issue_cnt_nxt = '0;
      hit_nxt       = 1'b0;
      best_vld_nxt  = 1'b0;
    end else begin
      if (issue) begin
        issue_cnt_nxt = CW'(issue_cnt_r + CW'(1));
      end
      if (state_r == S_SCAN && match) begin
        hit_nxt = 1'b1;
      end
      if (state_r == S_SCAN && take_old) begin
        best_vld_nxt = 1'b1;
      end
    end
  end

  // output beat register
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end
    if (state_r == S_DONE && out_free) begin
      out_valid_nxt = 1'b1;
    end
    fill_ext = {{FILL_W{1'b0}}, count_r};
    slot_ext = {{SLOT_W{1'b0}}, res_slot_r};
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      issue_cnt_r <= '0;
      rd_vld_r    <= 1'b0;
      hit_r       <= 1'b0;
      best_vld_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      issue_cnt_r <= issue_cnt_nxt;
      rd_vld_r    <= rd_vld_nxt;
      hit_r       <= hit_nxt;
      best_vld_r  <= best_vld_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_fire) begin
      op_r  <= in_op;
      key_r <= in_peer_key;
      mac_r <= in_peer_mac;
      now_r <= in_now_us;
    end
    if (issue) begin
      cmp_idx_r <= issue_cnt_r[IW-1:0];
    end
    if (state_r == S_SCAN && match && !hit_r) begin
      hit_idx_r <= cmp_idx_r;
      hit_mac_r <= rd_mac;
    end
    if (state_r == S_SCAN && take_old) begin
      best_idx_r  <= cmp_idx_r;
      best_seen_r <= rd_seen;
    end
    if (state_r == S_DECIDE) begin
      res_status_r <= dec_status;
      res_slot_r   <= dec_slot;
      res_mac_r    <= dec_mac;
    end
    if (state_r == S_DONE && out_free) begin
      out_status_r <= res_status_r;
      out_slot_r   <= slot_ext[SLOT_W-1:0];
      out_mac_r    <= res_mac_r;
      out_fill_r   <= fill_ext[FILL_W-1:0];
    end
  end

  assign out_valid      = out_valid_r;
  assign out_status     = out_status_r;
  assign out_slot       = out_slot_r;
  assign out_mac_out    = out_mac_r;
  assign out_fill_count = out_fill_r;

endmodule
`default_nettype wire
